[rtl/core/imds_pkg.sv]
// Shared types, codes and the microcode table of the Ising denoise step unit.
package imds_pkg;

  // Configuration register map.
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_TWO_GAMMA = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TWO_BETA  = 1'd1;
  localparam logic [CFG_DATA_W-1:0] TWO_GAMMA_RST = 16'd562;
  localparam logic [CFG_DATA_W-1:0] TWO_BETA_RST  = 16'd256;

  // Operation codes of an input word.
  localparam logic [1:0] OP_LOAD    = 2'd0;
  localparam logic [1:0] OP_PROPOSE = 2'd1;
  localparam logic [1:0] OP_READ    = 2'd2;

  typedef struct packed {
    logic [1:0]  operation;
    logic [7:0]  row;
    logic [7:0]  col;
    logic        pixel_in;
    logic [15:0] exp_variate;
  } in_word_t;

  typedef struct packed {
    logic pixel_out;
    logic noisy_out;
    logic flipped;
  } out_word_t;

  // Window positions: the center and the eight neighbors.
  localparam int unsigned NB_SEL_W = 4;
  localparam logic [NB_SEL_W-1:0] NB_CENTER = 4'd0;
  localparam logic [NB_SEL_W-1:0] NB_NW     = 4'd1;
  localparam logic [NB_SEL_W-1:0] NB_N      = 4'd2;
  localparam logic [NB_SEL_W-1:0] NB_NE     = 4'd3;
  localparam logic [NB_SEL_W-1:0] NB_W      = 4'd4;
  localparam logic [NB_SEL_W-1:0] NB_E      = 4'd5;
  localparam logic [NB_SEL_W-1:0] NB_SW     = 4'd6;
  localparam logic [NB_SEL_W-1:0] NB_S      = 4'd7;
  localparam logic [NB_SEL_W-1:0] NB_SE     = 4'd8;

  // Coordinate step codes.
  localparam logic [1:0] OFF_ZERO = 2'd0;
  localparam logic [1:0] OFF_DEC  = 2'd1;
  localparam logic [1:0] OFF_INC  = 2'd2;

  typedef struct packed {
    logic [1:0] dr;
    logic [1:0] dc;
  } nb_off_t;

  // Microprogram steps.
  localparam int unsigned PC_W = 5;
  localparam logic [PC_W-1:0] S_IDLE     = 5'd0;
  localparam logic [PC_W-1:0] S_DISPATCH = 5'd1;
  localparam logic [PC_W-1:0] S_P_RDC    = 5'd2;
  localparam logic [PC_W-1:0] S_P_NW     = 5'd3;
  localparam logic [PC_W-1:0] S_P_N      = 5'd4;
  localparam logic [PC_W-1:0] S_P_NE     = 5'd5;
  localparam logic [PC_W-1:0] S_P_W      = 5'd6;
  localparam logic [PC_W-1:0] S_P_E      = 5'd7;
  localparam logic [PC_W-1:0] S_P_SW     = 5'd8;
  localparam logic [PC_W-1:0] S_P_S      = 5'd9;
  localparam logic [PC_W-1:0] S_P_SE     = 5'd10;
  localparam logic [PC_W-1:0] S_P_ACC    = 5'd11;
  localparam logic [PC_W-1:0] S_P_MUL    = 5'd12;
  localparam logic [PC_W-1:0] S_P_CMP    = 5'd13;
  localparam logic [PC_W-1:0] S_FINISH   = 5'd14;
  localparam logic [PC_W-1:0] S_L_WR     = 5'd15;
  localparam logic [PC_W-1:0] S_R_RDC    = 5'd16;
  localparam logic [PC_W-1:0] S_R_CAP    = 5'd17;

  // Jump kinds.
  localparam logic [1:0] JMP_NEXT     = 2'd0;
  localparam logic [1:0] JMP_GOTO     = 2'd1;
  localparam logic [1:0] JMP_DISPATCH = 2'd2;

  // One control word of the microprogram.
  typedef struct packed {
    logic                wait_in;
    logic                done;
    logic [1:0]          jmp;
    logic [PC_W-1:0]     target;
    logic                clr;
    logic                rd_en;
    logic [NB_SEL_W-1:0] nb_sel;
    logic                wr_load;
    logic                cap;
    logic                acc;
    logic                mul;
    logic                cmp;
  } ucw_t;

  // Datapath status seen by the sequencer.
  typedef struct packed {
    logic [1:0] operation;
    logic       in_range;
    logic       out_stall;
  } dp_status_t;

  // Memory port controls from the datapath.
  typedef struct packed {
    logic rd_en;
    logic we_noisy;
    logic we_cur;
    logic wd;
  } mem_ctl_t;

  // Row and column step for each window position.
  function automatic nb_off_t nb_offset(input logic [NB_SEL_W-1:0] sel);
    nb_off_t o;
    o = '{dr: OFF_ZERO, dc: OFF_ZERO};
    unique case (sel)
      NB_NW:   o = '{dr: OFF_DEC,  dc: OFF_DEC};
      NB_N:    o = '{dr: OFF_DEC,  dc: OFF_ZERO};
      NB_NE:   o = '{dr: OFF_DEC,  dc: OFF_INC};
      NB_W:    o = '{dr: OFF_ZERO, dc: OFF_DEC};
      NB_E:    o = '{dr: OFF_ZERO, dc: OFF_INC};
      NB_SW:   o = '{dr: OFF_INC,  dc: OFF_DEC};
      NB_S:    o = '{dr: OFF_INC,  dc: OFF_ZERO};
      NB_SE:   o = '{dr: OFF_INC,  dc: OFF_INC};
      default: o = '{dr: OFF_ZERO, dc: OFF_ZERO};
    endcase
    return o;
  endfunction

  // The microprogram. A neighbor read step also folds in the data of the
  // read issued one step earlier.
  function automatic ucw_t ucode(input logic [PC_W-1:0] pc);
    ucw_t w;
    w = '0;
    w.nb_sel = NB_CENTER;
    unique case (pc)
      S_IDLE:     w.wait_in = 1'b1;
      S_DISPATCH: begin
        w.jmp = JMP_DISPATCH;
        w.clr = 1'b1;
      end
      S_P_RDC:    w.rd_en = 1'b1;
      S_P_NW: begin
        w.rd_en  = 1'b1;
        w.nb_sel = NB_NW;
        w.cap    = 1'b1;
      end
      S_P_N: begin
        w.rd_en = 1'b1; w.nb_sel = NB_N;  w.acc = 1'b1;
      end
      S_P_NE: begin
        w.rd_en = 1'b1; w.nb_sel = NB_NE; w.acc = 1'b1;
      end
      S_P_W: begin
        w.rd_en = 1'b1; w.nb_sel = NB_W;  w.acc = 1'b1;
      end
      S_P_E: begin
        w.rd_en = 1'b1; w.nb_sel = NB_E;  w.acc = 1'b1;
      end
      S_P_SW: begin
        w.rd_en = 1'b1; w.nb_sel = NB_SW; w.acc = 1'b1;
      end
      S_P_S: begin
        w.rd_en = 1'b1; w.nb_sel = NB_S;  w.acc = 1'b1;
      end
      S_P_SE: begin
        w.rd_en = 1'b1; w.nb_sel = NB_SE; w.acc = 1'b1;
      end
      S_P_ACC:    w.acc = 1'b1;
      S_P_MUL:    w.mul = 1'b1;
      S_P_CMP:    w.cmp = 1'b1;
      S_FINISH: begin
        w.done   = 1'b1;
        w.target = S_IDLE;
      end
      S_L_WR: begin
        w.wr_load = 1'b1;
        w.jmp     = JMP_GOTO;
        w.target  = S_FINISH;
      end
      S_R_RDC:    w.rd_en = 1'b1;
      S_R_CAP: begin
        w.cap    = 1'b1;
        w.jmp    = JMP_GOTO;
        w.target = S_FINISH;
      end
      default: begin
        w.jmp    = JMP_GOTO;
        w.target = S_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

[rtl/core/ising_metropolis_denoise_step_unit.sv]
// Top level of the Ising-model Metropolis denoise step unit.
//
// Input channel (in_valid/in_ready/in_data) takes one word per operation:
// load writes a pixel into the noisy and working images, propose runs one
// Metropolis flip test at a pixel with the given exponential variate, and
// read returns the stored pixels. Every accepted word yields one result word
// on the output channel (out_valid/out_ready/out_data). Positions outside the
// image change nothing and return all zeros.
// A microprogram steps a single-port pixel store; the nine window reads of a
// propose set its cost. The sequencer returns to idle as the result is
// registered, and only then takes a new word.
// The result sits in an output register: the next word is accepted while it
// waits, and only the finishing step of that next word holds off while the
// receiver stalls.
// Reset clears the sequencer and output valid and sets the weight registers
// to their defaults. The images are not cleared and must be loaded first.
// cfg_we writes two_gamma (index 0) or two_beta (index 1); the user must do
// so only while idle, which the block itself does not enforce.
module ising_metropolis_denoise_step_unit #(
  parameter int unsigned IMG_DIM = 256
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  imds_pkg::in_word_t              in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output imds_pkg::out_word_t             out_data,
  input  logic                            cfg_we,
  input  logic [imds_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [imds_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  localparam int unsigned AW = $clog2(IMG_DIM * IMG_DIM);

  imds_pkg::ucw_t       cw;
  imds_pkg::dp_status_t status;
  imds_pkg::mem_ctl_t   mem_ctl;
  logic [AW-1:0]        mem_addr;
  logic                 mem_q_noisy;
  logic                 mem_q_cur;
  logic                 in_fire;

  assign in_fire = in_valid & in_ready;

  // Microprogram control.
  imds_sequencer u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .status   (status),
    .cw       (cw),
    .in_ready (in_ready)
  );

  // Arithmetic and result datapath.
  imds_datapath #(
    .IMG_DIM (IMG_DIM)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cw          (cw),
    .in_fire     (in_fire),
    .in_data     (in_data),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .out_ready   (out_ready),
    .out_valid   (out_valid),
    .out_data    (out_data),
    .status      (status),
    .mem_addr    (mem_addr),
    .mem_ctl     (mem_ctl),
    .mem_q_noisy (mem_q_noisy),
    .mem_q_cur   (mem_q_cur)
  );

  // Image store.
  imds_pixel_mem #(
    .DEPTH (IMG_DIM * IMG_DIM)
  ) u_mem (
    .clk     (clk),
    .addr    (mem_addr),
    .ctl     (mem_ctl),
    .q_noisy (mem_q_noisy),
    .q_cur   (mem_q_cur)
  );

endmodule

[rtl/core/imds_pixel_mem.sv]
// Noisy and working image stores, one shared address, registered read data.
module imds_pixel_mem #(
  parameter int unsigned DEPTH = 65536
) (
  input  logic                     clk,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  imds_pkg::mem_ctl_t       ctl,
  output logic                     q_noisy,
  output logic                     q_cur
);

  logic noisy_mem [DEPTH];
  logic cur_mem   [DEPTH];

  // Noisy image: written by loads only.
  always_ff @(posedge clk) begin
    if (ctl.we_noisy) begin
      noisy_mem[addr] <= ctl.wd;
    end
    if (ctl.rd_en) begin
      q_noisy <= noisy_mem[addr];
    end
  end

  // Working image: written by loads and accepted flips.
  always_ff @(posedge clk) begin
    if (ctl.we_cur) begin
      cur_mem[addr] <= ctl.wd;
    end
    if (ctl.rd_en) begin
      q_cur <= cur_mem[addr];
    end
  end

endmodule

[rtl/core/imds_sequencer.sv]
// Microprogram counter with wait, dispatch and jump handling.
module imds_sequencer (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  imds_pkg::dp_status_t status,
  output imds_pkg::ucw_t       cw,
  output logic                 in_ready
);

  logic [imds_pkg::PC_W-1:0] pc_r;
  logic [imds_pkg::PC_W-1:0] pc_nxt;

  // Control word of the current step.
  assign cw       = imds_pkg::ucode(pc_r);
  assign in_ready = cw.wait_in;

  // Next step: hold for input or output, else follow the jump field.
  always_comb begin
    pc_nxt = pc_r;
    if (cw.wait_in) begin
      if (in_valid) begin
        pc_nxt = pc_r + imds_pkg::PC_W'(1);
      end
    end else if (cw.done) begin
      if (!status.out_stall) begin
        pc_nxt = cw.target;
      end
    end else begin
      unique case (cw.jmp)
        imds_pkg::JMP_NEXT: pc_nxt = pc_r + imds_pkg::PC_W'(1);
        imds_pkg::JMP_GOTO: pc_nxt = cw.target;
        imds_pkg::JMP_DISPATCH: begin
          if (!status.in_range) begin
            pc_nxt = imds_pkg::S_FINISH;
          end else if (status.operation == imds_pkg::OP_LOAD) begin
            pc_nxt = imds_pkg::S_L_WR;
          end else if (status.operation == imds_pkg::OP_PROPOSE) begin
            pc_nxt = imds_pkg::S_P_RDC;
          end else begin
            pc_nxt = imds_pkg::S_R_RDC;
          end
        end
        default: pc_nxt = imds_pkg::S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= imds_pkg::S_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

[rtl/core/imds_datapath.sv]
// Item register, window addressing, neighbor sum, energy test and result word.
module imds_datapath #(
  parameter int unsigned IMG_DIM = 256
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  imds_pkg::ucw_t                         cw,
  input  logic                                   in_fire,
  input  imds_pkg::in_word_t                     in_data,
  input  logic                                   cfg_we,
  input  logic [imds_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [imds_pkg::CFG_DATA_W-1:0]        cfg_wdata,
  input  logic                                   out_ready,
  output logic                                   out_valid,
  output imds_pkg::out_word_t                    out_data,
  output imds_pkg::dp_status_t                   status,
  output logic [$clog2(IMG_DIM*IMG_DIM)-1:0]     mem_addr,
  output imds_pkg::mem_ctl_t                     mem_ctl,
  input  logic                                   mem_q_noisy,
  input  logic                                   mem_q_cur
);

  localparam int unsigned CW = $clog2(IMG_DIM);
  localparam int unsigned AW = $clog2(IMG_DIM * IMG_DIM);

  imds_pkg::in_word_t  item_r;
  logic signed [15:0]  two_gamma_r;
  logic signed [15:0]  two_beta_r;
  logic signed [4:0]   sum_r;
  logic                x_r;
  logic                y_r;
  logic                flip_r;
  logic                nb_ok_r;
  logic signed [16:0]  t1_r;
  logic signed [20:0]  bs_r;
  imds_pkg::out_word_t out_data_r;
  logic                out_valid_r;

  logic [CW-1:0]       row_c;
  logic [CW-1:0]       col_c;
  logic [CW-1:0]       rr;
  logic [CW-1:0]       cc;
  logic                row_ok;
  logic                col_ok;
  imds_pkg::nb_off_t   off;
  logic                out_stall;
  logic                done_go;
  logic signed [16:0]  g_ext;
  logic signed [20:0]  t2;
  logic signed [21:0]  d_sum;
  logic signed [21:0]  e_val;
  logic                flip_ok;

  // Held item and its position; the range check guards the truncation.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      item_r <= in_data;
    end
  end

  assign row_c = CW'(item_r.row);
  assign col_c = CW'(item_r.col);

  assign out_stall = out_valid_r & ~out_ready;
  assign done_go   = cw.done & ~out_stall;

  assign status.operation = item_r.operation;
  assign status.in_range  = (32'(item_r.row) < IMG_DIM) && (32'(item_r.col) < IMG_DIM);
  assign status.out_stall = out_stall;

  // Neighbor coordinates and whether they fall inside the image.
  always_comb begin
    off    = imds_pkg::nb_offset(cw.nb_sel);
    rr     = row_c;
    cc     = col_c;
    row_ok = 1'b1;
    col_ok = 1'b1;
    case (off.dr)
      imds_pkg::OFF_DEC: begin
        rr     = row_c - CW'(1);
        row_ok = (row_c != '0);
      end
      imds_pkg::OFF_INC: begin
        rr     = row_c + CW'(1);
        row_ok = (row_c != CW'(IMG_DIM - 1));
      end
      default: begin
      end
    endcase
    case (off.dc)
      imds_pkg::OFF_DEC: begin
        cc     = col_c - CW'(1);
        col_ok = (col_c != '0);
      end
      imds_pkg::OFF_INC: begin
        cc     = col_c + CW'(1);
        col_ok = (col_c != CW'(IMG_DIM - 1));
      end
      default: begin
      end
    endcase
  end

  assign mem_addr = AW'(rr) * AW'(IMG_DIM) + AW'(cc);

  // Memory controls: loads write both images, an accepted flip writes the working one.
  assign mem_ctl.rd_en    = cw.rd_en;
  assign mem_ctl.we_noisy = cw.wr_load;
  assign mem_ctl.we_cur   = cw.wr_load | (cw.cmp & flip_ok);
  assign mem_ctl.wd       = cw.wr_load ? item_r.pixel_in : ~y_r;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      two_gamma_r <= imds_pkg::TWO_GAMMA_RST;
      two_beta_r  <= imds_pkg::TWO_BETA_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        imds_pkg::CFG_TWO_GAMMA: two_gamma_r <= cfg_wdata;
        imds_pkg::CFG_TWO_BETA:  two_beta_r  <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // Energy change against the variate: D = gamma term + beta term.
  assign g_ext   = 17'(two_gamma_r);
  assign t2      = y_r ? bs_r : -bs_r;
  assign d_sum   = 22'(t1_r) + 22'(t2);
  assign e_val   = 22'($signed({1'b0, item_r.exp_variate}));
  assign flip_ok = (d_sum < e_val);

  // Bounds flag is registered with its read, like the read data.
  always_ff @(posedge clk) begin
    if (cw.rd_en) begin
      nb_ok_r <= row_ok & col_ok;
    end
  end

  // Pixel, sum and product registers.
  always_ff @(posedge clk) begin
    if (cw.clr) begin
      sum_r  <= '0;
      x_r    <= 1'b0;
      y_r    <= 1'b0;
      flip_r <= 1'b0;
    end
    if (cw.wr_load) begin
      x_r <= item_r.pixel_in;
      y_r <= item_r.pixel_in;
    end
    if (cw.cap) begin
      x_r <= mem_q_noisy;
      y_r <= mem_q_cur;
    end
    if (cw.acc && nb_ok_r) begin
      sum_r <= sum_r + (mem_q_cur ? 5'sd1 : -5'sd1);
    end
    if (cw.mul) begin
      t1_r <= (x_r == y_r) ? g_ext : -g_ext;
      bs_r <= 21'(two_beta_r) * 21'(sum_r);
    end
    if (cw.cmp && flip_ok) begin
      y_r    <= ~y_r;
      flip_r <= 1'b1;
    end
  end

  // Result register: frees the sequencer while a word waits for the receiver.
  always_ff @(posedge clk) begin
    if (done_go) begin
      out_data_r <= '{pixel_out: y_r, noisy_out: x_r, flipped: flip_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (done_go) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[rtl/core/imds_checker.sv]
// Port-level checks of the denoise step unit, bound to its top level.
module imds_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input imds_pkg::out_word_t out_data
);

  // Right after reset the unit is ready and shows no result.
  a_reset_state: assert property (@(posedge clk) !rst_n |=> in_ready && !out_valid)
    else $error("unit not idle after reset");

  // One word at a time: acceptance closes the input until the word is done.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted twice in a row");

  // When a new result appears, the sequencer is back at idle.
  a_result_then_idle: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> in_ready)
    else $error("result shown while the unit is still busy");

  // A stalled result word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result word changed");

endmodule

bind ising_metropolis_denoise_step_unit imds_checker u_chk (.*);

[tb/ising_metropolis_denoise_step_unit_test.sv]
// Self-checking testbench for the Ising-model Metropolis denoise step unit.
`timescale 1ns / 100ps

module ising_metropolis_denoise_step_unit_test;

  localparam int IMG_DIM = 256;
  localparam int IMG_PIXELS = IMG_DIM * IMG_DIM;
  // The spare operation code behaves like a read.
  localparam logic [1:0] OP_SPARE = 2'd3;
  localparam int SEG_WORDS = 272;
  localparam int HOLD_AT = 1200;
  localparam int HOLD_CYCLES = 300;
  localparam int MAX_REPORTS = 200;

  typedef struct {
    imds_pkg::in_word_t  w;
    bit                  typed;
    imds_pkg::out_word_t want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  imds_pkg::in_word_t in_data;
  logic out_valid;
  logic out_ready = 1'b0;
  imds_pkg::out_word_t out_data;
  logic cfg_we;
  logic [imds_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [imds_pkg::CFG_DATA_W-1:0] cfg_wdata;

  // Shadow copies of the two images and the weight registers.
  logic noisy_img [IMG_PIXELS];
  logic cur_img [IMG_PIXELS];
  bit loaded [IMG_PIXELS];
  logic signed [15:0] two_gamma_q;
  logic signed [15:0] two_beta_q;

  imds_pkg::out_word_t pixels_due [$];
  dir_row_t dir_rows [$];
  int words_sent = 0;
  int bad_words = 0;
  int n_load = 0;
  int n_prop = 0;
  int n_flip = 0;
  int n_read = 0;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  logic rx_hold = 1'b0;

  ising_metropolis_denoise_step_unit #(
    .IMG_DIM(IMG_DIM)
  ) u_top (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  // Free-running 100 MHz clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Energy change of flipping one pixel, in the weights' 8-bit fraction scale.
  function automatic int energy_gap(input int r, input int c);
    int s, x, y, dr, dc, rr, cc;
    s = 0;
    for (dr = -1; dr <= 1; dr++) begin
      for (dc = -1; dc <= 1; dc++) begin
        rr = r + dr;
        cc = c + dc;
        if ((dr != 0 || dc != 0) && rr >= 0 && cc >= 0 && rr < IMG_DIM && cc < IMG_DIM) begin
          s += cur_img[rr * IMG_DIM + cc] ? 1 : -1;
        end
      end
    end
    x = noisy_img[r * IMG_DIM + c] ? 1 : -1;
    y = cur_img[r * IMG_DIM + c] ? 1 : -1;
    return int'(two_gamma_q) * x * y + int'(two_beta_q) * y * s;
  endfunction

  // Applies one word to the shadow images and returns the result it causes.
  function automatic imds_pkg::out_word_t denoise_step(input imds_pkg::in_word_t w);
    imds_pkg::out_word_t o;
    int r, c, idx;
    o = '0;
    r = int'(w.row);
    c = int'(w.col);
    if (r >= IMG_DIM || c >= IMG_DIM) return o;
    idx = r * IMG_DIM + c;
    case (w.operation)
      imds_pkg::OP_LOAD: begin
        noisy_img[idx] = w.pixel_in;
        cur_img[idx] = w.pixel_in;
        loaded[idx] = 1'b1;
      end
      imds_pkg::OP_PROPOSE: begin
        if (energy_gap(r, c) < int'({16'd0, w.exp_variate})) begin
          cur_img[idx] = ~cur_img[idx];
          o.flipped = 1'b1;
        end
      end
      default: begin
      end
    endcase
    o.pixel_out = cur_img[idx];
    o.noisy_out = noisy_img[idx];
    return o;
  endfunction

  function automatic imds_pkg::in_word_t make_word(input logic [1:0] op, input int r,
                                                   input int c, input logic pin,
                                                   input logic [15:0] e);
    imds_pkg::in_word_t w;
    w.operation = op;
    w.row = r[7:0];
    w.col = c[7:0];
    w.pixel_in = pin;
    w.exp_variate = e;
    return w;
  endfunction

  // Variates spread wide, low, or right at the flip threshold.
  function automatic logic [15:0] pick_variate(input int r, input int c);
    int v;
    case ($urandom_range(9))
      0, 1, 2, 3: v = $urandom_range(65535);
      4, 5, 6: v = $urandom_range(2047);
      default: v = energy_gap(r, c) + int'($urandom_range(2)) - 1;
    endcase
    if (v < 0) v = 0;
    if (v > 65535) v = 65535;
    return v[15:0];
  endfunction

  // Offers one word, waits for it to be taken and records what it should return.
  task automatic send_word(input imds_pkg::in_word_t w, input bit typed,
                           input imds_pkg::out_word_t want);
    imds_pkg::out_word_t got;
    @(negedge clk);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (!in_ready);
    got = denoise_step(w);
    if (typed) got = want;
    pixels_due.push_back(got);
    words_sent++;
    case (w.operation)
      imds_pkg::OP_LOAD: n_load++;
      imds_pkg::OP_PROPOSE: n_prop++;
      default: n_read++;
    endcase
    if (got.flipped) n_flip++;
  endtask

  // Loads every in-image pixel within reach of (r, c) that was never written.
  task automatic fill_window(input int r, input int c, input int reach);
    int dr, dc, rr, cc;
    for (dr = -reach; dr <= reach; dr++) begin
      for (dc = -reach; dc <= reach; dc++) begin
        rr = r + dr;
        cc = c + dc;
        if (rr >= 0 && cc >= 0 && rr < IMG_DIM && cc < IMG_DIM && !loaded[rr * IMG_DIM + cc]) begin
          send_word(make_word(imds_pkg::OP_LOAD, rr, cc, 1'($urandom_range(1)),
                              16'($urandom_range(65535))), 1'b0, '0);
        end
      end
    end
  endtask

  // A burst of words in a 4x4 patch, placed at corners, edges or anywhere.
  task automatic run_cluster(input int n_words);
    int rb, cb, k, r, c, pick;
    case ($urandom_range(3))
      0: rb = 0;
      1: rb = IMG_DIM - 4;
      default: rb = $urandom_range(IMG_DIM - 4);
    endcase
    case ($urandom_range(3))
      0: cb = 0;
      1: cb = IMG_DIM - 4;
      default: cb = $urandom_range(IMG_DIM - 4);
    endcase
    for (k = 0; k < n_words; k++) begin
      r = rb + $urandom_range(3);
      c = cb + $urandom_range(3);
      pick = $urandom_range(99);
      if (pick < 8) begin
        // Stray load anywhere in the image.
        send_word(make_word(imds_pkg::OP_LOAD, $urandom_range(IMG_DIM - 1),
                            $urandom_range(IMG_DIM - 1), 1'($urandom_range(1)),
                            16'($urandom_range(65535))), 1'b0, '0);
      end else if (pick < 22) begin
        send_word(make_word(imds_pkg::OP_LOAD, r, c, 1'($urandom_range(1)),
                            16'($urandom_range(65535))), 1'b0, '0);
      end else if (pick < 84) begin
        fill_window(r, c, 1);
        send_word(make_word(imds_pkg::OP_PROPOSE, r, c, 1'($urandom_range(1)),
                            pick_variate(r, c)), 1'b0, '0);
      end else begin
        fill_window(r, c, 0);
        send_word(make_word((pick < 95) ? imds_pkg::OP_READ : OP_SPARE, r, c,
                            1'($urandom_range(1)), 16'($urandom_range(65535))), 1'b0, '0);
      end
    end
  endtask

  // Lowers valid and waits for every outstanding result to come back.
  task automatic drain_words;
    @(negedge clk);
    in_valid <= 1'b0;
    while (pixels_due.size() != 0) @(posedge clk);
  endtask

  task automatic program_weights(input logic [15:0] g, input logic [15:0] b);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= imds_pkg::CFG_TWO_GAMMA;
    cfg_wdata <= g;
    @(negedge clk);
    cfg_index <= imds_pkg::CFG_TWO_BETA;
    cfg_wdata <= b;
    @(negedge clk);
    cfg_we <= 1'b0;
    two_gamma_q = g;
    two_beta_q = b;
  endtask

  task automatic add_row(input logic [1:0] op, input int r, input int c, input logic pin,
                         input logic [15:0] e, input bit typed,
                         input imds_pkg::out_word_t want);
    dir_row_t row;
    row.w = make_word(op, r, c, pin, e);
    row.typed = typed;
    row.want = want;
    dir_rows.push_back(row);
  endtask

  // Receiver: random stalls, overridden by the long hold-off.
  always @(negedge clk) begin
    out_ready <= !rx_hold && ($urandom_range(99) >= rx_idle_pct);
  end

  // Long receiver hold-off so the block fills up and blocks its input.
  initial begin
    wait (words_sent >= HOLD_AT);
    @(posedge clk);
    rx_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    rx_hold <= 1'b0;
  end

  // Result checker: every returned word against the oldest expectation.
  always @(posedge clk) begin : check_results
    imds_pkg::out_word_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pixels_due.size() == 0) begin
        bad_words++;
        if (bad_words <= MAX_REPORTS)
          $display("%0t: unexpected result word, actual %b", $time, out_data);
      end else begin
        want = pixels_due.pop_front();
        if (out_data.pixel_out !== want.pixel_out || out_data.noisy_out !== want.noisy_out ||
            out_data.flipped !== want.flipped) begin
          bad_words++;
          if (bad_words <= MAX_REPORTS)
            $display("%0t: pixel/noisy/flipped expected %b%b%b actual %b%b%b", $time,
                     want.pixel_out, want.noisy_out, want.flipped,
                     out_data.pixel_out, out_data.noisy_out, out_data.flipped);
        end
      end
    end
  end

  // Watchdog: a run that goes on far past its slowest correct length is a mismatch.
  initial begin
    #5_000_000;
    $display("ising_metropolis_denoise_step_unit: mismatch");
    $finish;
  end

  // Main sequence: reset, directed table, then random phases.
  initial begin
    int seg, target, i;
    logic [15:0] g, b;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_index = imds_pkg::CFG_TWO_GAMMA;
    cfg_wdata = '0;
    two_gamma_q = imds_pkg::TWO_GAMMA_RST;
    two_beta_q = imds_pkg::TWO_BETA_RST;
    for (i = 0; i < IMG_PIXELS; i++) begin
      noisy_img[i] = 1'b0;
      cur_img[i] = 1'b0;
      loaded[i] = 1'b0;
    end

    // Top-left corner: loads and reads, then flips around the threshold.
    add_row(imds_pkg::OP_LOAD, 0, 0, 1'b1, 16'hFFFF, 1'b1, 3'b110);
    add_row(imds_pkg::OP_LOAD, 0, 1, 1'b1, 16'h0000, 1'b1, 3'b110);
    add_row(imds_pkg::OP_LOAD, 1, 0, 1'b0, 16'h0000, 1'b1, 3'b000);
    add_row(imds_pkg::OP_LOAD, 1, 1, 1'b1, 16'h0000, 1'b1, 3'b110);
    add_row(imds_pkg::OP_READ, 0, 0, 1'b0, 16'h0000, 1'b1, 3'b110);
    add_row(OP_SPARE, 1, 0, 1'b1, 16'hFFFF, 1'b1, 3'b000);
    add_row(imds_pkg::OP_PROPOSE, 0, 0, 1'b0, 16'd0, 1'b0, '0);
    add_row(imds_pkg::OP_PROPOSE, 0, 0, 1'b0, 16'hFFFF, 1'b0, '0);
    add_row(imds_pkg::OP_PROPOSE, 0, 0, 1'b1, 16'd0, 1'b0, '0);
    // Variate equal to the energy change must not flip; one above must.
    add_row(imds_pkg::OP_PROPOSE, 0, 0, 1'b0, 16'd818, 1'b0, '0);
    add_row(imds_pkg::OP_PROPOSE, 0, 0, 1'b0, 16'd819, 1'b0, '0);
    // Bottom-right corner.
    add_row(imds_pkg::OP_LOAD, 255, 255, 1'b0, 16'h0000, 1'b1, 3'b000);
    add_row(imds_pkg::OP_LOAD, 255, 254, 1'b1, 16'h0000, 1'b1, 3'b110);
    add_row(imds_pkg::OP_LOAD, 254, 255, 1'b1, 16'h0000, 1'b1, 3'b110);
    add_row(imds_pkg::OP_LOAD, 254, 254, 1'b0, 16'hFFFF, 1'b1, 3'b000);
    add_row(imds_pkg::OP_PROPOSE, 255, 255, 1'b1, 16'hFFFF, 1'b0, '0);
    add_row(imds_pkg::OP_PROPOSE, 255, 255, 1'b0, 16'h8000, 1'b0, '0);
    add_row(imds_pkg::OP_READ, 255, 255, 1'b1, 16'h7FFF, 1'b0, '0);

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    tx_idle_pct = 14;
    rx_idle_pct = 87;
    foreach (dir_rows[k]) send_word(dir_rows[k].w, dir_rows[k].typed, dir_rows[k].want);

    // Random phases, each under its own weights and idling pattern.
    for (seg = 0; seg < 6; seg++) begin
      case (seg)
        0: begin g = 16'h8000; b = 16'h7FFF; end
        1: begin g = 16'h7FFF; b = 16'h8000; end
        2: begin g = 16'h0000; b = 16'h0000; end
        3: begin g = 16'($urandom); b = 16'($urandom); end
        4: begin g = imds_pkg::TWO_GAMMA_RST; b = imds_pkg::TWO_BETA_RST; end
        default: begin
          g = 16'($urandom_range(2048) - 1024);
          b = 16'($urandom_range(2048) - 1024);
        end
      endcase
      drain_words();
      program_weights(g, b);
      tx_idle_pct = (seg < 2) ? 14 : (seg < 4) ? 87 : 0;
      rx_idle_pct = (seg < 2) ? 87 : (seg < 4) ? 14 : 0;
      target = dir_rows.size() + (seg + 1) * SEG_WORDS;
      while (words_sent < target) run_cluster($urandom_range(40, 20));
    end

    drain_words();
    repeat (20) @(posedge clk);
    $display("Covered %0d words: %0d loads, %0d proposals (%0d flipped), %0d reads,",
             words_sent, n_load, n_prop, n_flip, n_read);
    $display("across six weight settings incl. extremes and a %0d-cycle receiver hold.",
             HOLD_CYCLES);
    if (bad_words == 0 && pixels_due.size() == 0) begin
      $display("ising_metropolis_denoise_step_unit: match");
    end else begin
      $display("ising_metropolis_denoise_step_unit: mismatch");
    end
    $finish;
  end

endmodule

[ising_metropolis_denoise_step_unit.f]
rtl/core/imds_pkg.sv
rtl/core/imds_pixel_mem.sv
rtl/core/imds_sequencer.sv
rtl/core/imds_datapath.sv
rtl/core/ising_metropolis_denoise_step_unit.sv
rtl/core/imds_checker.sv
tb/ising_metropolis_denoise_step_unit_test.sv
